// File: design/mpk_pkg.sv
package mpk_pkg;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned PRICE_W = 40;
    localparam int unsigned BID_W   = 40;
    localparam int unsigned ASK_W   = 63;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned MARGIN_W = 32;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_HOLD    = 3'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
    localparam logic [OP_W-1:0] OP_TRADE   = 3'd2;
    localparam logic [OP_W-1:0] OP_FUTURES = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK   = 3'd4;
    localparam logic [OP_W-1:0] OP_EST     = 3'd5;
    localparam logic [OP_W-1:0] OP_RESET   = 3'd6;
    localparam logic [OP_W-1:0] OP_INIT    = 3'd7;

    localparam logic [DIR_W-1:0] DIR_EMPTY = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LONG  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_SHORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_BUY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_SELL = 1'b1;

    localparam logic [ASK_W-1:0] ASK_UNKNOWN = {ASK_W{1'b1}};

    // One classified event as it travels from the front end to the back end.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               side;
        logic [SIZE_W-1:0]  size;
        logic [PRICE_W-1:0] price;
        logic               bid_ok;
        logic               ask_ok;
        logic               uses_mult;
        logic [BID_W-1:0]   bid;
        logic [ASK_W-1:0]   ask;
    } cmd_t;

endpackage

// File: design/margin_position_keeper.sv
// Channel   Handshake            Carries
// s_        s_valid / s_ready    opcode, side, size, price, price record, last bid, last ask
// m_        m_valid / m_ready    value, no increase flag, empty, direction, invalid flag
// cfg_      cfg_valid/cfg_ready  cfg_index (0 margin_buy, 1 margin_sell), cfg_data
//
// An item needs no 64-bit product, or one for an estimate, two for a trade or
// futures margin and three for an order check. Items that need none skip the
// multiplier. All products come from the single 32x32 multiplier, which makes
// one 64-bit wrapped product in three passes. Reset is synchronous and active
// low and clears the position, the margins, the queue and the output valid
// flag; no clearing pass follows.
// The input side stalls only when the command queue is full; the back end stalls
// while a finished result still waits in the output register.
module margin_position_keeper #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mpk_pkg::MARGIN_W-1:0]       cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mpk_pkg::OP_W-1:0]           s_opcode,
    input  logic                               s_side,
    input  logic [mpk_pkg::SIZE_W-1:0]         s_size,
    input  logic [mpk_pkg::PRICE_W-1:0]        s_price,
    input  logic                               s_price_record_present,
    input  logic [mpk_pkg::BID_W-1:0]          s_last_bid,
    input  logic [mpk_pkg::ASK_W-1:0]          s_last_ask,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mpk_pkg::WORD_W-1:0]  m_value,
    output logic                               m_no_margin_increase,
    output logic                               m_position_empty,
    output logic [mpk_pkg::DIR_W-1:0]          m_direction_now,
    output logic                               m_state_invalid
);

    logic          q_full, q_push, q_pop, q_empty;
    mpk_pkg::cmd_t push_cmd, pop_cmd;

    // The front end classifies each item and drops it into the queue.
    mpk_front u_front (
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_opcode               (s_opcode),
        .s_side                 (s_side),
        .s_size                 (s_size),
        .s_price                (s_price),
        .s_price_record_present (s_price_record_present),
        .s_last_bid             (s_last_bid),
        .s_last_ask             (s_last_ask),
        .q_full                 (q_full),
        .q_push                 (q_push),
        .q_cmd                  (push_cmd)
    );

    // A short queue lets the front end keep accepting while the back end works.
    mpk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    // The back end holds the position, runs the multiplier and delivers results.
    mpk_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .q_empty              (q_empty),
        .q_cmd                (pop_cmd),
        .q_pop                (q_pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_value              (m_value),
        .m_no_margin_increase (m_no_margin_increase),
        .m_position_empty     (m_position_empty),
        .m_direction_now      (m_direction_now),
        .m_state_invalid      (m_state_invalid)
    );

endmodule

// File: design/mpk_front.sv
module mpk_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mpk_pkg::OP_W-1:0]      s_opcode,
    input  logic                          s_side,
    input  logic [mpk_pkg::SIZE_W-1:0]    s_size,
    input  logic [mpk_pkg::PRICE_W-1:0]   s_price,
    input  logic                          s_price_record_present,
    input  logic [mpk_pkg::BID_W-1:0]     s_last_bid,
    input  logic [mpk_pkg::ASK_W-1:0]     s_last_ask,
    input  logic                          q_full,
    output logic                          q_push,
    output mpk_pkg::cmd_t                 q_cmd
);

    // Decide up front whether the market prices can be used for an estimate
    // and whether the event needs the multiplier at all.
    always_comb begin
        q_cmd.op        = s_opcode;
        q_cmd.side      = s_side;
        q_cmd.size      = s_size;
        q_cmd.price     = s_price;
        q_cmd.bid_ok    = s_price_record_present && (s_last_bid != '0);
        q_cmd.ask_ok    = s_price_record_present && (s_last_ask != mpk_pkg::ASK_UNKNOWN);
        q_cmd.uses_mult = (s_opcode == mpk_pkg::OP_TRADE) || (s_opcode == mpk_pkg::OP_FUTURES)
                       || (s_opcode == mpk_pkg::OP_CHECK) || (s_opcode == mpk_pkg::OP_EST);
        q_cmd.bid       = s_last_bid;
        q_cmd.ask       = s_last_ask;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

// File: design/mpk_queue.sv
module mpk_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mpk_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output mpk_pkg::cmd_t pop_cmd,
    output logic          empty
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    mpk_pkg::cmd_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/mpk_back.sv
module mpk_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mpk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpk_pkg::MARGIN_W-1:0]    cfg_data,
    input  logic                            q_empty,
    input  mpk_pkg::cmd_t                   q_cmd,
    output logic                            q_pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [mpk_pkg::WORD_W-1:0] m_value,
    output logic                            m_no_margin_increase,
    output logic                            m_position_empty,
    output logic [mpk_pkg::DIR_W-1:0]       m_direction_now,
    output logic                            m_state_invalid
);

    localparam int unsigned W = mpk_pkg::WORD_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_EXEC = 3'd4;

    function automatic logic [W-1:0] smax(input logic [W-1:0] a, input logic [W-1:0] b);
        return ($signed(a) < $signed(b)) ? b : a;
    endfunction

    function automatic logic spos(input logic [W-1:0] a);
        return (a != '0) && !a[W-1];
    endfunction

    // Configuration
    logic [mpk_pkg::MARGIN_W-1:0] mbuy_reg, msell_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbuy_reg  <= '0;
            msell_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == mpk_pkg::REG_MARGIN_BUY) begin
                mbuy_reg <= cfg_data;
            end else begin
                msell_reg <= cfg_data;
            end
        end
    end

    // Position state
    logic [mpk_pkg::DIR_W-1:0] dir_reg, dir_next;
    logic [W-1:0] vol_reg, vol_next;
    logic [W-1:0] psum_reg, psum_next;
    logic [W-1:0] profit_reg, profit_next;
    logic [W-1:0] pbuy_reg, pbuy_next;
    logic [W-1:0] psell_reg, psell_next;

    // Sequencer
    logic [2:0] state_reg, state_next;
    mpk_pkg::cmd_t cmd_reg;
    logic [1:0] nmul_reg;
    logic [1:0] k_reg, k_next;
    logic [1:0] st_reg, st_next;
    logic [W-1:0] opa_reg [3];
    logic [W-1:0] opb_reg [3];
    logic [W-1:0] prod_reg [3];

    // Multiplier pipeline
    logic [W-1:0] pp_reg;
    logic         pp_v_reg, pp_sh_reg, pp_first_reg, pp_last_reg;
    logic [1:0]   pp_k_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] acc_sum;
    logic [31:0]  mul_a, mul_b;
    logic [W-1:0] mul_a_full, mul_b_full;

    // Output register
    logic          m_valid_reg;
    logic [W-1:0]  m_value_reg;
    logic          m_noinc_reg, m_empty_reg, m_invalid_reg;
    logic [mpk_pkg::DIR_W-1:0] m_dir_reg;

    logic         exec_fire;
    logic [W-1:0] sp, size64, price64;
    logic [W-1:0] value_c;
    logic         noinc_c, empty_c, invalid_c;
    logic [mpk_pkg::DIR_W-1:0] own;
    logic         opp;
    logic [W-1:0] to_open, cur, nw, mbn, msn;

    assign size64  = W'(cmd_reg.size);
    assign price64 = W'(cmd_reg.price);
    assign sp = (dir_reg == mpk_pkg::DIR_LONG)  ? vol_reg :
                (dir_reg == mpk_pkg::DIR_SHORT) ? (W'(0) - vol_reg) : W'(0);

    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        st_next    = st_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                k_next     = '0;
                st_next    = '0;
                state_next = cmd_reg.uses_mult ? ST_MUL : ST_EXEC;
            end
            ST_MUL: begin
                if (st_reg == 2'd2) begin
                    st_next = '0;
                    if (k_reg == nmul_reg - 1'b1) begin
                        state_next = ST_WAIT;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    st_next = st_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // One 32x32 partial product per cycle; three make a 64-bit wrapped product.
    assign mul_a_full = opa_reg[k_reg];
    assign mul_b_full = opb_reg[k_reg];

    always_comb begin
        case (st_reg)
            2'd0: begin
                mul_a = mul_a_full[31:0];
                mul_b = mul_b_full[31:0];
            end
            2'd1: begin
                mul_a = mul_a_full[31:0];
                mul_b = mul_b_full[63:32];
            end
            default: begin
                mul_a = mul_a_full[63:32];
                mul_b = mul_b_full[31:0];
            end
        endcase
    end

    assign acc_sum = (pp_first_reg ? W'(0) : acc_reg) + (pp_sh_reg ? (pp_reg << 32) : pp_reg);

    always_ff @(posedge aclk) begin
        pp_reg       <= W'(mul_a) * W'(mul_b);
        pp_sh_reg    <= (st_reg != 2'd0);
        pp_first_reg <= (st_reg == 2'd0);
        pp_last_reg  <= (st_reg == 2'd2);
        pp_k_reg     <= k_reg;
        if (pp_v_reg) begin
            acc_reg <= acc_sum;
            if (pp_last_reg) begin
                prod_reg[pp_k_reg] <= acc_sum;
            end
        end
    end

    // Operand selection for the products each event needs.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == ST_LOAD) begin
            case (cmd_reg.op)
                mpk_pkg::OP_TRADE: begin
                    nmul_reg   <= 2'd2;
                    opa_reg[0] <= size64;
                    opb_reg[0] <= price64;
                    opa_reg[1] <= vol_reg;
                    opb_reg[1] <= price64;
                end
                mpk_pkg::OP_FUTURES, mpk_pkg::OP_CHECK: begin
                    nmul_reg   <= (cmd_reg.op == mpk_pkg::OP_CHECK) ? 2'd3 : 2'd2;
                    opa_reg[0] <= W'(mbuy_reg);
                    opb_reg[0] <= pbuy_reg + sp;
                    opa_reg[1] <= W'(msell_reg);
                    opb_reg[1] <= psell_reg - sp;
                    opa_reg[2] <= cmd_reg.side ? W'(msell_reg) : W'(mbuy_reg);
                    opb_reg[2] <= size64;
                end
                mpk_pkg::OP_EST: begin
                    nmul_reg   <= 2'd1;
                    opa_reg[0] <= vol_reg;
                    if (dir_reg == mpk_pkg::DIR_LONG) begin
                        opb_reg[0] <= cmd_reg.bid_ok ? W'(cmd_reg.bid) : W'(mbuy_reg);
                    end else begin
                        opb_reg[0] <= cmd_reg.ask_ok ? W'(cmd_reg.ask) : W'(msell_reg);
                    end
                end
                default: begin
                    nmul_reg <= 2'd0;
                end
            endcase
        end
    end

    // Event execution on the finished products.
    always_comb begin
        dir_next    = dir_reg;
        vol_next    = vol_reg;
        psum_next   = psum_reg;
        profit_next = profit_reg;
        pbuy_next   = pbuy_reg;
        psell_next  = psell_reg;
        value_c     = '0;
        noinc_c     = 1'b0;
        own         = cmd_reg.side ? mpk_pkg::DIR_SHORT : mpk_pkg::DIR_LONG;
        opp         = (dir_reg != mpk_pkg::DIR_EMPTY) && (dir_reg != own);
        to_open     = size64;
        cur         = smax(prod_reg[0], prod_reg[1]);
        mbn         = prod_reg[0] + (cmd_reg.side ? W'(0) : prod_reg[2]);
        msn         = prod_reg[1] + (cmd_reg.side ? prod_reg[2] : W'(0));
        nw          = smax(mbn, msn);
        case (cmd_reg.op)
            mpk_pkg::OP_HOLD: begin
                if (cmd_reg.side) begin
                    psell_next = psell_reg + size64;
                end else begin
                    pbuy_next = pbuy_reg + size64;
                end
            end
            mpk_pkg::OP_RELEASE: begin
                if (cmd_reg.side) begin
                    psell_next = psell_reg - size64;
                end else begin
                    pbuy_next = pbuy_reg - size64;
                end
            end
            mpk_pkg::OP_TRADE: begin
                if (cmd_reg.side) begin
                    psell_next = psell_reg - size64;
                end else begin
                    pbuy_next = pbuy_reg - size64;
                end
                if (opp && ($signed(size64) < $signed(vol_reg))) begin
                    // The trade only shrinks the opposite position.
                    vol_next  = vol_reg - size64;
                    psum_next = psum_reg - prod_reg[0];
                    value_c   = '0;
                end else if (opp) begin
                    // Close the opposite position, book the profit, open the rest.
                    if (dir_reg == mpk_pkg::DIR_LONG) begin
                        profit_next = profit_reg + (prod_reg[1] - psum_reg);
                    end else if (dir_reg == mpk_pkg::DIR_SHORT) begin
                        profit_next = profit_reg + (psum_reg - prod_reg[1]);
                    end
                    to_open = size64 - vol_reg;
                    if (spos(to_open)) begin
                        vol_next  = to_open;
                        psum_next = prod_reg[0] - prod_reg[1];
                        dir_next  = own;
                    end else begin
                        vol_next  = '0;
                        psum_next = '0;
                        dir_next  = mpk_pkg::DIR_EMPTY;
                    end
                    value_c = to_open;
                end else begin
                    if (size64 != '0) begin
                        vol_next  = vol_reg + size64;
                        psum_next = psum_reg + prod_reg[0];
                        dir_next  = own;
                    end
                    value_c = size64;
                end
            end
            mpk_pkg::OP_FUTURES: begin
                value_c = cur;
            end
            mpk_pkg::OP_CHECK: begin
                if (!($signed(cur) < $signed(nw))) begin
                    value_c = '1;
                    noinc_c = 1'b1;
                end else begin
                    value_c = nw;
                end
            end
            mpk_pkg::OP_EST: begin
                if (dir_reg == mpk_pkg::DIR_LONG) begin
                    value_c = profit_reg + (cmd_reg.bid_ok ? (prod_reg[0] - psum_reg) : prod_reg[0]);
                end else if (dir_reg == mpk_pkg::DIR_SHORT) begin
                    value_c = profit_reg + (cmd_reg.ask_ok ? (psum_reg - prod_reg[0]) : prod_reg[0]);
                end else begin
                    value_c = profit_reg;
                end
            end
            mpk_pkg::OP_RESET: begin
                dir_next   = mpk_pkg::DIR_EMPTY;
                vol_next   = '0;
                psum_next  = '0;
                pbuy_next  = '0;
                psell_next = '0;
            end
            default: begin
                dir_next    = mpk_pkg::DIR_EMPTY;
                vol_next    = '0;
                psum_next   = '0;
                profit_next = '0;
                pbuy_next   = '0;
                psell_next  = '0;
            end
        endcase
        empty_c = (dir_next == mpk_pkg::DIR_EMPTY) && (psell_next == '0) && (pbuy_next == '0);
        if (dir_next == mpk_pkg::DIR_EMPTY) begin
            invalid_c = (vol_next != '0) || (psum_next != '0);
        end else if (dir_next == mpk_pkg::DIR_LONG || dir_next == mpk_pkg::DIR_SHORT) begin
            invalid_c = !spos(vol_next) || !spos(psum_next);
        end else begin
            invalid_c = 1'b1;
        end
        invalid_c = invalid_c || psell_next[W-1] || pbuy_next[W-1];
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_value_reg   <= value_c;
            m_noinc_reg   <= noinc_c;
            m_empty_reg   <= empty_c;
            m_dir_reg     <= dir_next;
            m_invalid_reg <= invalid_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            st_reg      <= '0;
            pp_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            dir_reg     <= mpk_pkg::DIR_EMPTY;
            vol_reg     <= '0;
            psum_reg    <= '0;
            profit_reg  <= '0;
            pbuy_reg    <= '0;
            psell_reg   <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            st_reg    <= st_next;
            pp_v_reg  <= (state_reg == ST_MUL);
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
                dir_reg     <= dir_next;
                vol_reg     <= vol_next;
                psum_reg    <= psum_next;
                profit_reg  <= profit_next;
                pbuy_reg    <= pbuy_next;
                psell_reg   <= psell_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_value              = $signed(m_value_reg);
    assign m_no_margin_increase = m_noinc_reg;
    assign m_position_empty     = m_empty_reg;
    assign m_direction_now      = m_dir_reg;
    assign m_state_invalid      = m_invalid_reg;

endmodule
